[hw/rtl/spq_pkg.sv]
// Package for the stable priority queue: codes, payload types and defaults.
// Used by the channel interfaces, the queue cell and the top level.
package spq_pkg;

    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int REC_W           = 16;
    localparam int LVL_W           = 2;

    typedef logic [REC_W-1:0] rec_t;
    typedef logic [LVL_W-1:0] lvl_t;

    localparam lvl_t LVL_MAX = lvl_t'(2);

    typedef enum logic [1:0] {
        MODE_ENQ      = 2'd0,
        MODE_DEQ      = 2'd1,
        MODE_LIST_ALL = 2'd2,
        MODE_LIST_LVL = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_SHIFT  = 2'd2,
        OP_ROTATE = 2'd3
    } cell_op_t;

    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_LIST = 1'b1
    } fsm_t;

    typedef struct packed {
        cell_op_t op;
        rec_t     rec;
        lvl_t     lvl;
    } spq_cmd_t;

endpackage

[hw/rtl/spq_if.sv]
// Valid/ready channel interfaces for request and response items.
// Depends on spq_pkg for the payload types.
interface spq_req_if;
    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    spq_pkg::rec_t     record_number;
    spq_pkg::lvl_t     priority_req;

    modport source (output valid, output mode, output record_number, output priority_req,
                    input ready);
    modport sink   (input valid, input mode, input record_number, input priority_req,
                    output ready);
endinterface

interface spq_rsp_if;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    spq_pkg::rec_t     out_record_number;
    spq_pkg::lvl_t     out_priority;
    logic              last;

    modport source (output valid, output status, output out_record_number,
                    output out_priority, output last, input ready);
    modport sink   (input valid, input status, input out_record_number,
                    input out_priority, input last, output ready);
endinterface

[hw/rtl/spq_cell.sv]
// One slot of the sorted chain: holds an entry and moves it with its neighbors.
// Depends on spq_pkg for the command struct and payload types.
module spq_cell (
    input  logic              clk,
    input  spq_pkg::spq_cmd_t cmd,
    input  logic              occ,
    input  logic              tail,
    input  logic              prev_ge,
    input  spq_pkg::rec_t     prev_rec,
    input  spq_pkg::lvl_t     prev_lvl,
    input  spq_pkg::rec_t     next_rec,
    input  spq_pkg::lvl_t     next_lvl,
    input  spq_pkg::rec_t     head_rec,
    input  spq_pkg::lvl_t     head_lvl,
    output logic              ge,
    output spq_pkg::rec_t     rec,
    output spq_pkg::lvl_t     lvl
);

    spq_pkg::rec_t rec_reg, rec_next;
    spq_pkg::lvl_t lvl_reg, lvl_next;

    assign ge  = occ && (lvl_reg >= cmd.lvl);
    assign rec = rec_reg;
    assign lvl = lvl_reg;

    always_comb
    begin
        rec_next = rec_reg;
        lvl_next = lvl_reg;
        unique case (cmd.op)
            spq_pkg::OP_HOLD:
            begin
                rec_next = rec_reg;
                lvl_next = lvl_reg;
            end
            spq_pkg::OP_INSERT:
            begin
                if (!ge)
                begin
                    if (prev_ge)
                    begin
                        rec_next = cmd.rec;
                        lvl_next = cmd.lvl;
                    end
                    else
                    begin
                        rec_next = prev_rec;
                        lvl_next = prev_lvl;
                    end
                end
            end
            spq_pkg::OP_SHIFT:
            begin
                rec_next = next_rec;
                lvl_next = next_lvl;
            end
            spq_pkg::OP_ROTATE:
            begin
                if (tail)
                begin
                    rec_next = head_rec;
                    lvl_next = head_lvl;
                end
                else
                begin
                    rec_next = next_rec;
                    lvl_next = next_lvl;
                end
            end
            default:
            begin
                rec_next = rec_reg;
                lvl_next = lvl_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
        lvl_reg <= lvl_next;
    end

endmodule

[hw/rtl/stable_priority_queue.sv]
// Top level of the stable three-level priority queue: control and cell chain.
// Depends on spq_pkg, spq_if (spq_req_if, spq_rsp_if) and spq_cell.
//
//  channel  dir  fields
//  req      in   mode, record_number, priority_req
//  rsp      out  status, out_record_number, out_priority, last
//
// On enqueue and dequeue the cell chain inserts or shifts in the accept cycle
// and the result lands in the output register.
// During a listing the chain rotates one entry per cycle past the head while the
// response is not stalled, and one matching entry is held back to mark the final result.
// Reset empties the queue at once; cell contents are not cleared.
// A stalled response holds the chain and blocks new requests.
module stable_priority_queue #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    spq_req_if.sink    req,
    spq_rsp_if.source  rsp
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    spq_pkg::fsm_t     state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              pend_valid_reg, pend_valid_next;
    spq_pkg::rec_t     pend_rec_reg, pend_rec_next;
    spq_pkg::lvl_t     pend_lvl_reg, pend_lvl_next;
    logic              list_all_reg, list_all_next;
    spq_pkg::lvl_t     list_lvl_reg, list_lvl_next;
    logic              out_valid_reg, out_valid_next;
    spq_pkg::status_t  out_status_reg, out_status_next;
    spq_pkg::rec_t     out_rec_reg, out_rec_next;
    spq_pkg::lvl_t     out_lvl_reg, out_lvl_next;
    logic              out_last_reg, out_last_next;

    spq_pkg::spq_cmd_t cmd;
    spq_pkg::lvl_t     req_lvl_sat;
    logic              out_free;
    logic              accept;
    logic              full;
    logic              match;

    spq_pkg::rec_t     rec_w [QUEUE_DEPTH];
    spq_pkg::lvl_t     lvl_w [QUEUE_DEPTH];
    logic              ge_w  [QUEUE_DEPTH];

    assign out_free    = !out_valid_reg || rsp.ready;
    assign req.ready   = (state_reg == spq_pkg::FSM_IDLE) && out_free;
    assign accept      = req.valid && req.ready;
    assign full        = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign req_lvl_sat = (req.priority_req > spq_pkg::LVL_MAX) ? spq_pkg::LVL_MAX
                                                               : req.priority_req;
    assign match       = list_all_reg || (lvl_w[0] == list_lvl_reg);

    assign rsp.valid             = out_valid_reg;
    assign rsp.status            = out_status_reg;
    assign rsp.out_record_number = out_rec_reg;
    assign rsp.out_priority      = out_lvl_reg;
    assign rsp.last              = out_last_reg;

    generate
        for (genvar i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            logic          prev_ge;
            spq_pkg::rec_t prev_rec;
            spq_pkg::lvl_t prev_lvl;
            spq_pkg::rec_t next_rec;
            spq_pkg::lvl_t next_lvl;

            if (i == 0)
            begin : g_first
                assign prev_ge  = 1'b1;
                assign prev_rec = cmd.rec;
                assign prev_lvl = cmd.lvl;
            end
            else
            begin : g_mid
                assign prev_ge  = ge_w[i-1];
                assign prev_rec = rec_w[i-1];
                assign prev_lvl = lvl_w[i-1];
            end

            if (i == QUEUE_DEPTH - 1)
            begin : g_last
                assign next_rec = rec_w[i];
                assign next_lvl = lvl_w[i];
            end
            else
            begin : g_inner
                assign next_rec = rec_w[i+1];
                assign next_lvl = lvl_w[i+1];
            end

            spq_cell u_cell (
                .clk      (clk),
                .cmd      (cmd),
                .occ      (count_reg > CNT_W'(i)),
                .tail     (count_reg == CNT_W'(i + 1)),
                .prev_ge  (prev_ge),
                .prev_rec (prev_rec),
                .prev_lvl (prev_lvl),
                .next_rec (next_rec),
                .next_lvl (next_lvl),
                .head_rec (rec_w[0]),
                .head_lvl (lvl_w[0]),
                .ge       (ge_w[i]),
                .rec      (rec_w[i]),
                .lvl      (lvl_w[i])
            );
        end
    endgenerate

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_rec_next   = pend_rec_reg;
        pend_lvl_next   = pend_lvl_reg;
        list_all_next   = list_all_reg;
        list_lvl_next   = list_lvl_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_rec_next    = out_rec_reg;
        out_lvl_next    = out_lvl_reg;
        out_last_next   = out_last_reg;
        cmd.op          = spq_pkg::OP_HOLD;
        cmd.rec         = req.record_number;
        cmd.lvl         = req_lvl_sat;

        unique case (state_reg)
            spq_pkg::FSM_IDLE:
            begin
                if (accept)
                begin
                    unique case (spq_pkg::mode_t'(req.mode)) inside
                        spq_pkg::MODE_ENQ:
                        begin
                            out_valid_next = 1'b1;
                            out_last_next  = 1'b1;
                            if (full)
                            begin
                                out_status_next = spq_pkg::ST_FULL;
                                out_rec_next    = '0;
                                out_lvl_next    = '0;
                            end
                            else
                            begin
                                cmd.op          = spq_pkg::OP_INSERT;
                                count_next      = count_reg + 1'b1;
                                out_status_next = spq_pkg::ST_OK;
                                out_rec_next    = req.record_number;
                                out_lvl_next    = req_lvl_sat;
                            end
                        end
                        spq_pkg::MODE_DEQ:
                        begin
                            out_valid_next = 1'b1;
                            out_last_next  = 1'b1;
                            if (count_reg == '0)
                            begin
                                out_status_next = spq_pkg::ST_EMPTY;
                                out_rec_next    = '0;
                                out_lvl_next    = '0;
                            end
                            else
                            begin
                                cmd.op          = spq_pkg::OP_SHIFT;
                                count_next      = count_reg - 1'b1;
                                out_status_next = spq_pkg::ST_OK;
                                out_rec_next    = rec_w[0];
                                out_lvl_next    = lvl_w[0];
                            end
                        end
                        spq_pkg::MODE_LIST_ALL, spq_pkg::MODE_LIST_LVL:
                        begin
                            state_next      = spq_pkg::FSM_LIST;
                            idx_next        = '0;
                            pend_valid_next = 1'b0;
                            list_all_next   = (req.mode == spq_pkg::MODE_LIST_ALL);
                            list_lvl_next   = req.priority_req;
                        end
                        default:
                        begin
                            state_next = spq_pkg::FSM_IDLE;
                        end
                    endcase
                end
            end
            spq_pkg::FSM_LIST:
            begin
                if (out_free)
                begin
                    if (idx_reg == count_reg)
                    begin
                        state_next     = spq_pkg::FSM_IDLE;
                        out_valid_next = 1'b1;
                        out_last_next  = 1'b1;
                        if (pend_valid_reg)
                        begin
                            out_status_next = spq_pkg::ST_OK;
                            out_rec_next    = pend_rec_reg;
                            out_lvl_next    = pend_lvl_reg;
                        end
                        else
                        begin
                            out_status_next = spq_pkg::ST_EMPTY;
                            out_rec_next    = '0;
                            out_lvl_next    = '0;
                        end
                    end
                    else
                    begin
                        cmd.op   = spq_pkg::OP_ROTATE;
                        idx_next = idx_reg + 1'b1;
                        if (match)
                        begin
                            pend_valid_next = 1'b1;
                            pend_rec_next   = rec_w[0];
                            pend_lvl_next   = lvl_w[0];
                            if (pend_valid_reg)
                            begin
                                out_valid_next  = 1'b1;
                                out_last_next   = 1'b0;
                                out_status_next = spq_pkg::ST_OK;
                                out_rec_next    = pend_rec_reg;
                                out_lvl_next    = pend_lvl_reg;
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = spq_pkg::FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= spq_pkg::FSM_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_rec_reg   <= pend_rec_next;
        pend_lvl_reg   <= pend_lvl_next;
        list_all_reg   <= list_all_next;
        list_lvl_reg   <= list_lvl_next;
        out_status_reg <= out_status_next;
        out_rec_reg    <= out_rec_next;
        out_lvl_reg    <= out_lvl_next;
        out_last_reg   <= out_last_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_list_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spq_pkg::FSM_LIST) |-> !req.ready)
        else $error("request taken during listing");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spq_pkg::FSM_LIST) |-> (idx_reg <= count_reg))
        else $error("listing index past entry count");

    a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.mode == spq_pkg::MODE_ENQ) && !full)
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("enqueue did not grow the queue");

endmodule
